// ===== rtl/fmlp_pkg.sv =====
`default_nettype none

package fmlp_pkg;

    // Network shape: three inputs, two hidden layers of four neurons, one output.
    localparam int NIN  = 3;
    localparam int NHID = 4;

    // Payload field types at the port widths.
    typedef logic signed [15:0] in_t;
    typedef logic [19:0]        h1_t;
    typedef logic [23:0]        h2_t;
    typedef logic signed [28:0] out_t;

    // Packed vectors of one layer's neuron values.
    typedef logic [NHID-1:0][19:0] h1_vec_t;
    typedef logic [NHID-1:0][23:0] h2_vec_t;

    // Accumulator types, each wide enough for the signed sum of its layer.
    typedef logic signed [21:0] acc1_t;
    typedef logic signed [25:0] acc2_t;
    typedef logic signed [29:0] acc3_t;

    // Integer weights, row = source neuron, column = destination neuron.
    typedef logic signed [4:0] wt_t;

    localparam wt_t WT1 [NIN][NHID] = '{
        '{-5'sd6,  5'sd10,  5'sd5,  5'sd1},
        '{ 5'sd8, -5'sd7,   5'sd1, -5'sd1},
        '{ 5'sd4,  5'sd7,  -5'sd3, -5'sd2}
    };

    // The rows for sources three and four are the same.
    localparam wt_t WT2 [NHID][NHID] = '{
        '{-5'sd3,  5'sd4,  5'sd5,  5'sd9},
        '{ 5'sd6, -5'sd7,  5'sd1,  5'sd4},
        '{ 5'sd3, -5'sd3, -5'sd3, -5'sd3},
        '{ 5'sd3, -5'sd3, -5'sd3, -5'sd3}
    };

    localparam wt_t WT3 [NHID] = '{5'sd2, -5'sd1, 5'sd1, 5'sd7};

    // Per-stage load enables from the pipeline control to the datapath.
    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } fmlp_adv_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_mlp_relu_inference_top.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata  48 bits: in_a, in_b, in_c
// m_*       out        m_tvalid / m_tready  m_tdata 208 bits: hid1_n0..3, hid2_n0..3, net_out
//
// Each request passes through three register stages: the first hidden layer, the
// second hidden layer and the output neuron. One request can enter every cycle while
// the output side is not stalled. The last stage is the output register.
// Reset clears the stage valid bits only; the datapath registers carry no reset.
// Each stage holds while its successor is full and stalled, so bubbles close up and
// a stall on the output side loses and repeats nothing.

module fixed_mlp_relu_inference_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0 up: in_a[15:0], in_b[31:16], in_c[47:32].
    input  wire logic [47:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0 up: hid1_n0[19:0], hid1_n1[39:20], hid1_n2[59:40],
    // hid1_n3[79:60], hid2_n0[103:80], hid2_n1[127:104], hid2_n2[151:128],
    // hid2_n3[175:152], net_out[204:176], zero pad [207:205].
    output logic [207:0]      m_tdata
);
    import fmlp_pkg::*;

    fmlp_adv_t adv;
    logic      v1_reg;
    logic      v1_next;
    logic      v2_reg;
    logic      v2_next;
    logic      v3_reg;
    logic      v3_next;
    h1_vec_t   hid1;
    h2_vec_t   hid2;
    out_t      net_out;

    // A stage loads when it is empty or its contents move on in the same cycle.
    always_comb
    begin
        adv.adv3 = !v3_reg || m_tready;
        adv.adv2 = !v2_reg || adv.adv3;
        adv.adv1 = !v1_reg || adv.adv2;
        v1_next  = adv.adv1 ? s_tvalid : v1_reg;
        v2_next  = adv.adv2 ? v1_reg   : v2_reg;
        v3_next  = adv.adv3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    fmlp_core u_core (
        .clk     (clk),
        .adv     (adv),
        .in_a    (s_tdata[15:0]),
        .in_b    (s_tdata[31:16]),
        .in_c    (s_tdata[47:32]),
        .hid1    (hid1),
        .hid2    (hid2),
        .net_out (net_out)
    );

    assign s_tready = adv.adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = {3'b000, net_out, hid2, hid1};

endmodule

`default_nettype wire

// ===== rtl/fmlp_core.sv =====
`default_nettype none

module fmlp_core (
    input  wire logic                clk,
    input  wire fmlp_pkg::fmlp_adv_t adv,
    input  wire fmlp_pkg::in_t       in_a,
    input  wire fmlp_pkg::in_t       in_b,
    input  wire fmlp_pkg::in_t       in_c,
    output fmlp_pkg::h1_vec_t        hid1,
    output fmlp_pkg::h2_vec_t        hid2,
    output fmlp_pkg::out_t           net_out
);
    import fmlp_pkg::*;

    h1_vec_t h1_next;
    h1_vec_t h1_reg;
    h1_vec_t h1_p2_reg;
    h1_vec_t h1_p3_reg;
    h2_vec_t h2_next;
    h2_vec_t h2_reg;
    h2_vec_t h2_p3_reg;
    out_t    y_next;
    out_t    y_reg;

    in_t x [NIN];

    assign x[0] = in_a;
    assign x[1] = in_b;
    assign x[2] = in_c;

    // Stage one: first layer sums with ReLU.
    always_comb
    begin
        acc1_t s;
        for (int i = 0; i < NHID; i++)
        begin
            s = '0;
            for (int j = 0; j < NIN; j++)
            begin
                s = s + acc1_t'(x[j]) * acc1_t'(WT1[j][i]);
            end
            h1_next[i] = s[21] ? '0 : s[19:0];
        end
    end

    // Stage two: second layer sums with ReLU on the registered first layer.
    always_comb
    begin
        acc2_t s;
        for (int i = 0; i < NHID; i++)
        begin
            s = '0;
            for (int j = 0; j < NHID; j++)
            begin
                s = s + acc2_t'({1'b0, h1_reg[j]}) * acc2_t'(WT2[j][i]);
            end
            h2_next[i] = s[25] ? '0 : s[23:0];
        end
    end

    // Stage three: output neuron, a plain weighted sum.
    always_comb
    begin
        acc3_t s;
        s = '0;
        for (int j = 0; j < NHID; j++)
        begin
            s = s + acc3_t'({1'b0, h2_reg[j]}) * acc3_t'(WT3[j]);
        end
        y_next = s[28:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv1)
        begin
            h1_reg <= h1_next;
        end
        if (adv.adv2)
        begin
            h1_p2_reg <= h1_reg;
            h2_reg    <= h2_next;
        end
        if (adv.adv3)
        begin
            h1_p3_reg <= h1_p2_reg;
            h2_p3_reg <= h2_reg;
            y_reg     <= y_next;
        end
    end

    assign hid1    = h1_p3_reg;
    assign hid2    = h2_p3_reg;
    assign net_out = y_reg;

endmodule

`default_nettype wire
